>>> src/svar_pkg.sv
// Shared types and event codes for the scroll / video-address register block.
package svar_pkg;

    localparam int unsigned ADDR_W = 15;
    localparam int unsigned FETCH_W = 14;

    // Event codes carried in the mode field
    localparam logic [3:0] MODE_CTRL_WR   = 4'd0;
    localparam logic [3:0] MODE_MASK_WR   = 4'd1;
    localparam logic [3:0] MODE_STATUS_RD = 4'd2;
    localparam logic [3:0] MODE_SCROLL_WR = 4'd3;
    localparam logic [3:0] MODE_ADDR_WR   = 4'd4;
    localparam logic [3:0] MODE_DATA      = 4'd5;
    localparam logic [3:0] MODE_INC_X     = 4'd6;
    localparam logic [3:0] MODE_INC_Y     = 4'd7;
    localparam logic [3:0] MODE_COPY_X    = 4'd8;
    localparam logic [3:0] MODE_COPY_Y    = 4'd9;

    localparam logic [4:0] COARSE_MAX    = 5'd31;
    localparam logic [4:0] COARSE_Y_LAST = 5'd29;

    typedef struct packed {
        logic [ADDR_W-1:0] vram_addr;
        logic [ADDR_W-1:0] temp_addr;
        logic [2:0]        fine_x;
        logic              toggle;
        logic              increment_32;
        logic              render_enable;
    } t_state;

    typedef struct packed {
        logic [2:0]         attribute_shift;
        logic [FETCH_W-1:0] attribute_address;
        logic [FETCH_W-1:0] nametable_address;
        logic [FETCH_W-1:0] access_address;
        logic               write_toggle;
        logic [2:0]         fine_scroll_x;
        logic [ADDR_W-1:0]  temp_address;
        logic [ADDR_W-1:0]  current_address;
    } t_result;

endpackage

>>> src/svar_update.sv
// Next-state logic for one event applied to the scroll / address registers.
module svar_update (
    input  logic [3:0]      i_mode,
    input  logic [7:0]      i_data_byte,
    input  svar_pkg::t_state i_state,
    output svar_pkg::t_state o_state
);
    import svar_pkg::*;

    logic [ADDR_W-1:0] w_v;
    logic [ADDR_W-1:0] w_inc_x;
    logic [ADDR_W-1:0] w_inc_y;
    logic [4:0]        w_cy;
    logic [ADDR_W-1:0] w_step;

    assign w_v = i_state.vram_addr;
    assign w_cy = w_v[9:5];
    assign w_step = i_state.increment_32 ? ADDR_W'(32) : ADDR_W'(1);

    // coarse x: 31 wraps and flips the horizontal nametable
    always_comb begin
        w_inc_x = w_v;
        if (w_v[4:0] == COARSE_MAX) begin
            w_inc_x[4:0] = '0;
            w_inc_x[10]  = ~w_v[10];
        end else begin
            w_inc_x[4:0] = w_v[4:0] + 5'd1;
        end
    end

    // fine y, then coarse y with the attribute-row wrap
    always_comb begin
        w_inc_y = w_v;
        if (w_v[14:12] != 3'd7) begin
            w_inc_y[14:12] = w_v[14:12] + 3'd1;
        end else begin
            w_inc_y[14:12] = '0;
            if (w_cy == COARSE_Y_LAST) begin
                w_inc_y[9:5] = '0;
                w_inc_y[11]  = ~w_v[11];
            end else if (w_cy == COARSE_MAX) begin
                w_inc_y[9:5] = '0;
            end else begin
                w_inc_y[9:5] = w_cy + 5'd1;
            end
        end
    end

    always_comb begin
        o_state = i_state;
        unique case (i_mode)
            MODE_CTRL_WR: begin
                o_state.temp_addr[11:10] = i_data_byte[1:0];
                o_state.increment_32     = i_data_byte[2];
            end
            MODE_MASK_WR: begin
                o_state.render_enable = i_data_byte[3] | i_data_byte[4];
            end
            MODE_STATUS_RD: begin
                o_state.toggle = 1'b0;
            end
            MODE_SCROLL_WR: begin
                if (!i_state.toggle) begin
                    o_state.fine_x          = i_data_byte[2:0];
                    o_state.temp_addr[4:0]  = i_data_byte[7:3];
                end else begin
                    o_state.temp_addr[14:12] = i_data_byte[2:0];
                    o_state.temp_addr[9:5]   = i_data_byte[7:3];
                end
                o_state.toggle = ~i_state.toggle;
            end
            MODE_ADDR_WR: begin
                if (!i_state.toggle) begin
                    o_state.temp_addr[14]   = 1'b0;
                    o_state.temp_addr[13:8] = i_data_byte[5:0];
                end else begin
                    o_state.temp_addr[7:0] = i_data_byte;
                    o_state.vram_addr      = {i_state.temp_addr[14:8], i_data_byte};
                end
                o_state.toggle = ~i_state.toggle;
            end
            MODE_DATA: begin
                o_state.vram_addr = w_v + w_step;
            end
            MODE_INC_X: begin
                if (i_state.render_enable) o_state.vram_addr = w_inc_x;
            end
            MODE_INC_Y: begin
                if (i_state.render_enable) o_state.vram_addr = w_inc_y;
            end
            MODE_COPY_X: begin
                if (i_state.render_enable) begin
                    o_state.vram_addr[10]  = i_state.temp_addr[10];
                    o_state.vram_addr[4:0] = i_state.temp_addr[4:0];
                end
            end
            MODE_COPY_Y: begin
                if (i_state.render_enable) begin
                    o_state.vram_addr[14:11] = i_state.temp_addr[14:11];
                    o_state.vram_addr[9:5]   = i_state.temp_addr[9:5];
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> src/svar_fetch_addr.sv
// Result word assembly: registers plus tile and attribute fetch addresses.
module svar_fetch_addr (
    input  svar_pkg::t_state  i_state,
    input  logic [svar_pkg::ADDR_W-1:0] i_before,
    output svar_pkg::t_result o_result
);
    import svar_pkg::*;

    logic [ADDR_W-1:0] w_v;

    assign w_v = i_state.vram_addr;

    always_comb begin
        o_result.current_address   = w_v;
        o_result.temp_address      = i_state.temp_addr;
        o_result.fine_scroll_x     = i_state.fine_x;
        o_result.write_toggle      = i_state.toggle;
        o_result.access_address    = i_before[FETCH_W-1:0];
        // 0x2000 | v[11:0]
        o_result.nametable_address = {2'b10, w_v[11:0]};
        // 0x23C0 | nametable | coarse y[4:2] << 3 | coarse x[4:2]
        o_result.attribute_address = {2'b10, w_v[11:10], 4'b1111, w_v[9:7], w_v[4:2]};
        o_result.attribute_shift   = {w_v[6], w_v[1], 1'b0};
    end

endmodule

>>> src/scroll_vram_address_registers_core.sv
// Top level of the scroll / video-address register block.
// Each input word is one event (register write, status read, data access or render
// step) and yields exactly one output word with v, t, fine x, the write toggle and the
// fetch addresses derived from v. The result word passes through the input register,
// then the result register, before it is presented; one event is taken every
// cycle, limited only by output back pressure.
// The input register feeds one level of next-state logic that updates v/t/x/w and
// loads the result register in the same cycle, so events chain back to back.
module scroll_vram_address_registers_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [3:0] mode, [11:4] data_byte, [15:12] zero
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // [14:0] current_address, [29:15] temp_address,
                                     // [32:30] fine_scroll_x, [33] write_toggle,
                                     // [47:34] access_address, [61:48] nametable_address,
                                     // [75:62] attribute_address, [78:76] attribute_shift,
                                     // [79] zero
);
    import svar_pkg::*;

    // input register
    logic       r_in_valid;
    logic [3:0] r_mode;
    logic [7:0] r_data_byte;

    // architectural state
    t_state r_state;
    t_state n_state;

    // result register
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;

    logic w_advance;   // event in the input register moves into the result register
    logic w_accept;

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;

    svar_update u_update (
        .i_mode      (r_mode),
        .i_data_byte (r_data_byte),
        .i_state     (r_state),
        .o_state     (n_state)
    );

    svar_fetch_addr u_fetch (
        .i_state  (n_state),
        .i_before (r_state.vram_addr),
        .o_result (n_result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= i_s_tdata[3:0];
            r_data_byte <= i_s_tdata[11:4];
        end
    end

    // v/t/x/w and mode flags change only when an event is applied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // output stage: holds a finished word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_result};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the scroll / video-address register block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import svar_pkg::*;

    // Codes 10..15 are unused event codes: they change nothing but still give a word
    localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AT      = 400;  // input words accepted before the long stall
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 20;   // wait after the last result word, before the end of the run
    localparam int unsigned MAX_REPORTS  = 10;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;

    scroll_vram_address_registers_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),     // [3:0] mode, [11:4] data_byte, [15:12] zero
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)   // [14:0] v, [29:15] t, [32:30] fine x, [33] toggle,
                                  // [47:34] access, [61:48] nametable, [75:62] attribute,
                                  // [78:76] attribute shift, [79] zero
    );

    // Event words waiting to be offered, and register snapshots waiting to come out
    logic [15:0] event_q[$];
    t_result     expected_regs_q[$];

    // Shadow copy of v, t, fine x, toggle, increment and render enable
    t_state      shadow;

    int unsigned total_events = 0;
    int unsigned n_sent       = 0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;

    int unsigned tx_gap    = 0;
    bit          tx_steady = 1'b0;
    int unsigned rx_stall  = 0;
    bit          rx_steady = 1'b0;

    logic        hold      = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one event to the shadow registers and queue the word the block must return
    task automatic predict_registers(input logic [3:0] mode, input logic [7:0] d);
        logic [ADDR_W-1:0] v_before;
        logic [ADDR_W-1:0] v;
        t_result           r;
        v_before = shadow.vram_addr;
        case (mode)
            MODE_CTRL_WR: begin
                shadow.temp_addr[11:10] = d[1:0];
                shadow.increment_32     = d[2];
            end
            MODE_MASK_WR: begin
                shadow.render_enable = d[3] | d[4];
            end
            MODE_STATUS_RD: begin
                shadow.toggle = 1'b0;
            end
            MODE_SCROLL_WR: begin
                if (!shadow.toggle) begin
                    shadow.fine_x         = d[2:0];
                    shadow.temp_addr[4:0] = d[7:3];
                end else begin
                    shadow.temp_addr[14:12] = d[2:0];
                    shadow.temp_addr[9:5]   = d[7:3];
                end
                shadow.toggle = ~shadow.toggle;
            end
            MODE_ADDR_WR: begin
                if (!shadow.toggle) begin
                    shadow.temp_addr[14]   = 1'b0;
                    shadow.temp_addr[13:8] = d[5:0];
                end else begin
                    shadow.temp_addr[7:0] = d;
                    shadow.vram_addr      = shadow.temp_addr;
                end
                shadow.toggle = ~shadow.toggle;
            end
            MODE_DATA: begin
                shadow.vram_addr = shadow.vram_addr + (shadow.increment_32 ? 15'd32 : 15'd1);
            end
            MODE_INC_X: begin
                if (shadow.render_enable) begin
                    if (shadow.vram_addr[4:0] == COARSE_MAX) begin
                        shadow.vram_addr[4:0] = '0;
                        shadow.vram_addr[10]  = ~shadow.vram_addr[10];
                    end else begin
                        shadow.vram_addr[4:0] = shadow.vram_addr[4:0] + 5'd1;
                    end
                end
            end
            MODE_INC_Y: begin
                if (shadow.render_enable) begin
                    if (shadow.vram_addr[14:12] != 3'd7) begin
                        shadow.vram_addr[14:12] = shadow.vram_addr[14:12] + 3'd1;
                    end else begin
                        shadow.vram_addr[14:12] = '0;
                        // row 29 is the last visible row: wrap and flip vertical nametable
                        if (shadow.vram_addr[9:5] == COARSE_Y_LAST) begin
                            shadow.vram_addr[9:5] = '0;
                            shadow.vram_addr[11]  = ~shadow.vram_addr[11];
                        end else if (shadow.vram_addr[9:5] == COARSE_MAX) begin
                            shadow.vram_addr[9:5] = '0;
                        end else begin
                            shadow.vram_addr[9:5] = shadow.vram_addr[9:5] + 5'd1;
                        end
                    end
                end
            end
            MODE_COPY_X: begin
                if (shadow.render_enable) begin
                    shadow.vram_addr[10]  = shadow.temp_addr[10];
                    shadow.vram_addr[4:0] = shadow.temp_addr[4:0];
                end
            end
            MODE_COPY_Y: begin
                if (shadow.render_enable) begin
                    shadow.vram_addr[14:11] = shadow.temp_addr[14:11];
                    shadow.vram_addr[9:5]   = shadow.temp_addr[9:5];
                end
            end
            default: begin
            end
        endcase
        v = shadow.vram_addr;
        r.current_address   = v;
        r.temp_address      = shadow.temp_addr;
        r.fine_scroll_x     = shadow.fine_x;
        r.write_toggle      = shadow.toggle;
        r.access_address    = v_before[FETCH_W-1:0];
        r.nametable_address = {2'b10, v[11:0]};
        r.attribute_address = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
        r.attribute_shift   = {v[6], v[1], 1'b0};
        expected_regs_q.push_back(r);
    endtask

    task automatic add_event(input logic [3:0] mode, input logic [7:0] d);
        event_q.push_back({4'b0000, d, mode});
    endtask

    task automatic check_field(input string name, input logic [14:0] want,
                               input logic [14:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Stimulus: directed events first, then random sequences shaped like frames
    initial begin : stimulus
        int unsigned kind;
        int unsigned n;
        logic [7:0]  d;

        // render steps while rendering is off must not move v
        add_event(MODE_CTRL_WR, 8'hFF);
        add_event(MODE_ADDR_WR, 8'hFF);   add_event(MODE_ADDR_WR, 8'hFF);
        add_event(MODE_INC_X, 8'h00);     add_event(MODE_INC_Y, 8'hFF);
        add_event(MODE_COPY_X, 8'h00);    add_event(MODE_COPY_Y, 8'h00);
        add_event(MODE_MASK_WR, 8'hE7);   // no enable bit set
        add_event(MODE_DATA, 8'h5A);      // step of 32
        add_event(MODE_MASK_WR, 8'h10);
        // t to all ones, copy both halves, then a data access wraps v at 15 bits
        add_event(MODE_SCROLL_WR, 8'hFF); add_event(MODE_SCROLL_WR, 8'hFF);
        add_event(MODE_COPY_X, 8'h00);    add_event(MODE_COPY_Y, 8'h00);
        add_event(MODE_CTRL_WR, 8'h00);   add_event(MODE_DATA, 8'hFF);
        // status read drops the toggle mid pair
        add_event(MODE_SCROLL_WR, 8'hF8); add_event(MODE_STATUS_RD, 8'hFF);
        // coarse x 31, fine y 7, coarse y 29: both wraps with nametable flips
        add_event(MODE_SCROLL_WR, 8'hF8); add_event(MODE_SCROLL_WR, 8'hEF);
        add_event(MODE_COPY_Y, 8'h00);    add_event(MODE_COPY_X, 8'h00);
        add_event(MODE_INC_Y, 8'h00);     add_event(MODE_INC_X, 8'h00);
        // coarse y 31 wraps without a flip
        add_event(MODE_SCROLL_WR, 8'h00); add_event(MODE_SCROLL_WR, 8'hFF);
        add_event(MODE_COPY_Y, 8'h00);    add_event(MODE_INC_Y, 8'h00);
        add_event(MODE_UNUSED_LO, 8'hFF); add_event(MODE_UNUSED_HI, 8'h00);

        n = event_q.size() + RANDOM_ITEMS;
        while (event_q.size() < n) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    // noise: any code, any byte
                    add_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                end
                1: begin
                    // half a pair, flips the toggle
                    add_event($urandom_range(0, 1) ? MODE_SCROLL_WR : MODE_ADDR_WR,
                              8'($urandom_range(0, 255)));
                end
                2: begin
                    // frame setup: status, control, mask, scroll pair
                    add_event(MODE_STATUS_RD, 8'($urandom_range(0, 255)));
                    add_event(MODE_CTRL_WR, 8'($urandom_range(0, 255)));
                    d = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0)
                        d[3] = 1'b1;
                    add_event(MODE_MASK_WR, d);
                    add_event(MODE_SCROLL_WR, 8'($urandom_range(0, 255)));
                    d = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) == 0)
                        d = {5'($urandom_range(28, 31)), 3'd7};  // near the y wraps
                    add_event(MODE_SCROLL_WR, d);
                    add_event(MODE_COPY_Y, 8'($urandom_range(0, 255)));
                end
                3, 4: begin
                    // address pair followed by a burst of data accesses
                    add_event(MODE_ADDR_WR, 8'($urandom_range(0, 255)));
                    add_event(MODE_ADDR_WR, 8'($urandom_range(0, 255)));
                    n += 0;
                    repeat ($urandom_range(1, 6))
                        add_event(MODE_DATA, 8'($urandom_range(0, 255)));
                end
                default: begin
                    // one scanline of render steps
                    repeat ($urandom_range(1, 34))
                        add_event(MODE_INC_X, 8'($urandom_range(0, 255)));
                    add_event(MODE_INC_Y, 8'($urandom_range(0, 255)));
                    add_event(MODE_COPY_X, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 7) == 0)
                        add_event(MODE_COPY_Y, 8'($urandom_range(0, 255)));
                end
            endcase
        end
        total_events = event_q.size();
    end

    // Reset once, then wait for every word to come back
    initial begin : sequencer
        shadow = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent < total_events || expected_regs_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_regs_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Driver: offers queued events, with a random gap (none in steady runs) after each accepted word
    always @(posedge i_clk) begin
        bit slot_free;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            slot_free = !s_valid;
            if (s_valid && o_s_tready) begin
                predict_registers(s_data[3:0], s_data[11:4]);
                n_sent <= n_sent + 1;
                slot_free = 1'b1;
                if ($urandom_range(0, 19) == 0)
                    tx_steady = !tx_steady;
                tx_gap = tx_steady ? 0 : $urandom_range(0, 9);
            end
            if (slot_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (event_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= event_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver stall while the driver keeps pushing, to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold <= 1'b0;
        end else if (!hold_done && !hold && n_sent >= HOLD_AT) begin
            hold      <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold) begin
            if (hold_left == 1) begin
                hold      <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compares each output word with the oldest snapshot
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                got = o_m_tdata[78:0];
                if (expected_regs_q.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected output word %h", o_m_tdata);
                    errors++;
                end else begin
                    want = expected_regs_q.pop_front();
                    check_field("current_address", want.current_address, got.current_address);
                    check_field("temp_address", want.temp_address, got.temp_address);
                    check_field("fine_scroll_x", 15'(want.fine_scroll_x),
                                15'(got.fine_scroll_x));
                    check_field("write_toggle", 15'(want.write_toggle),
                                15'(got.write_toggle));
                    check_field("access_address", 15'(want.access_address),
                                15'(got.access_address));
                    check_field("nametable_address", 15'(want.nametable_address),
                                15'(got.nametable_address));
                    check_field("attribute_address", 15'(want.attribute_address),
                                15'(got.attribute_address));
                    check_field("attribute_shift", 15'(want.attribute_shift),
                                15'(got.attribute_shift));
                end
                if ($urandom_range(0, 19) == 0)
                    rx_steady = !rx_steady;
                rx_stall = rx_steady ? 0 : $urandom_range(0, 9);
            end else if (!m_ready && rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= (rx_stall == 0) && !hold;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
